>>> src/nnts_pkg.sv
`default_nettype none

package nnts_pkg;

    // fixed field widths
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int PIX_W     = 32;
    localparam int DIM_OUT_W = 13;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SIDE      = 2'd2;

    // register reset values
    localparam logic [CFG_W-1:0] RST_SOURCE_WIDTH  = 13'd1;
    localparam logic [CFG_W-1:0] RST_SOURCE_HEIGHT = 13'd1;
    localparam logic [CFG_W-1:0] RST_MAX_SIDE      = 13'd512;

    typedef enum logic [3:0] {
        ST_SETUP,
        ST_FIT_LOAD,
        ST_FIT_DIV,
        ST_FIT_END,
        ST_COL_LOAD,
        ST_COL_DIV,
        ST_COL_END,
        ST_ROW_LOAD,
        ST_ROW_DIV,
        ST_ROW_END,
        ST_RUN
    } nnts_state_t;

    typedef enum logic [1:0] {
        DIV_FIT,
        DIV_COL,
        DIV_ROW
    } nnts_div_sel_t;

    typedef struct packed {
        logic          setup;
        logic          div_load;
        nnts_div_sel_t div_sel;
        logic          div_step;
        logic          fit_pass;
        logic          fit_store;
        logic          col_store;
        logic          row_store;
        logic          run;
    } nnts_cmd_t;

    typedef struct packed {
        logic restart;
        logic needs_fit;
    } nnts_status_t;

    // rgba to bgra: swap the red and blue bytes
    function automatic logic [PIX_W-1:0] swizzle_bgra(input logic [PIX_W-1:0] px);
        return {px[31:24], px[7:0], px[15:8], px[23:16]};
    endfunction

endpackage

`default_nettype wire

>>> src/nnts_pix_in_if.sv
`default_nettype none

interface nnts_pix_in_if;
    import nnts_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_rgba;

    modport source (output valid, output pixel_rgba, input ready);
    modport sink   (input valid, input pixel_rgba, output ready);
endinterface

`default_nettype wire

>>> src/nnts_pix_out_if.sv
`default_nettype none

interface nnts_pix_out_if;
    import nnts_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [PIX_W-1:0]     pixel_bgra;
    logic [DIM_OUT_W-1:0] thumb_width;
    logic [DIM_OUT_W-1:0] thumb_height;
    logic                 frame_last;

    modport source (output valid, output pixel_bgra, output thumb_width,
                    output thumb_height, output frame_last, input ready);
    modport sink   (input valid, input pixel_bgra, input thumb_width,
                    input thumb_height, input frame_last, output ready);
endinterface

`default_nettype wire

>>> src/nnts_ctrl.sv
`default_nettype none

module nnts_ctrl #(
    parameter int DIV_BITS = 26
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  nnts_pkg::nnts_status_t status,
    output nnts_pkg::nnts_cmd_t    cmd
);
    import nnts_pkg::*;

    localparam int CNT_W = $clog2(DIV_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_BITS - 1);

    nnts_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_SETUP;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ST_FIT_LOAD;
            end
            ST_FIT_LOAD: begin
                if (status.needs_fit) begin
                    cmd.div_load = 1'b1;
                    cmd.div_sel  = DIV_FIT;
                    cnt_next     = '0;
                    state_next   = ST_FIT_DIV;
                end else begin
                    cmd.fit_pass = 1'b1;
                    state_next   = ST_COL_LOAD;
                end
            end
            ST_FIT_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_FIT_END;
                end
            end
            ST_FIT_END: begin
                cmd.fit_store = 1'b1;
                state_next    = ST_COL_LOAD;
            end
            ST_COL_LOAD: begin
                cmd.div_load = 1'b1;
                cmd.div_sel  = DIV_COL;
                cnt_next     = '0;
                state_next   = ST_COL_DIV;
            end
            ST_COL_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_COL_END;
                end
            end
            ST_COL_END: begin
                cmd.col_store = 1'b1;
                state_next    = ST_ROW_LOAD;
            end
            ST_ROW_LOAD: begin
                cmd.div_load = 1'b1;
                cmd.div_sel  = DIV_ROW;
                cnt_next     = '0;
                state_next   = ST_ROW_DIV;
            end
            ST_ROW_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_ROW_END;
                end
            end
            ST_ROW_END: begin
                cmd.row_store = 1'b1;
                state_next    = ST_RUN;
            end
            ST_RUN: begin
                cmd.run = 1'b1;
            end
            default: begin
                state_next = ST_SETUP;
            end
        endcase
        // any write to a defined register restarts the size setup
        if (status.restart) begin
            state_next = ST_SETUP;
        end
    end

endmodule

`default_nettype wire

>>> src/nnts_dp.sv
`default_nettype none

module nnts_dp #(
    parameter int MAX_DIMENSION = 4096
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_wr_en,
    input  wire  [nnts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [nnts_pkg::CFG_W-1:0]        cfg_wr_data,
    input  nnts_pkg::nnts_cmd_t               cmd,
    output nnts_pkg::nnts_status_t            status,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire  [nnts_pkg::PIX_W-1:0]        in_pixel,
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic [nnts_pkg::PIX_W-1:0]        out_pixel,
    output logic [nnts_pkg::DIM_OUT_W-1:0]    out_thumb_width,
    output logic [nnts_pkg::DIM_OUT_W-1:0]    out_thumb_height,
    output logic                              out_frame_last
);
    import nnts_pkg::*;

    localparam int CW = $clog2(MAX_DIMENSION + 1);
    localparam int DW = (CW > CFG_W) ? CW : CFG_W;
    localparam int NW = 2 * DW;
    localparam logic [DW-1:0] MAX_DIM_V = DW'(MAX_DIMENSION);

    function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [DW-1:0] ext;
        ext = DW'(v);
        if (ext == '0) begin
            return DW'(1);
        end else if (ext > MAX_DIM_V) begin
            return MAX_DIM_V;
        end
        return ext;
    endfunction

    // register file
    logic [CFG_W-1:0] src_w_cfg_reg, src_h_cfg_reg, max_cfg_reg;
    logic             cfg_hit;

    assign cfg_hit = cfg_wr_en && (cfg_index == REG_SOURCE_WIDTH ||
                                   cfg_index == REG_SOURCE_HEIGHT ||
                                   cfg_index == REG_MAX_SIDE);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            src_w_cfg_reg <= RST_SOURCE_WIDTH;
            src_h_cfg_reg <= RST_SOURCE_HEIGHT;
            max_cfg_reg   <= RST_MAX_SIDE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SOURCE_WIDTH:  src_w_cfg_reg <= cfg_wr_data;
                REG_SOURCE_HEIGHT: src_h_cfg_reg <= cfg_wr_data;
                REG_MAX_SIDE:      max_cfg_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // frame geometry, set up before the frame runs
    logic [DW-1:0] w_reg, h_reg, m_reg;
    logic [DW-1:0] fw_reg, fh_reg;
    logic [DW-1:0] col_q_reg, col_r_reg, row_q_reg, row_r_reg;
    logic          wide;

    assign wide             = (w_reg >= h_reg);
    assign status.restart   = cfg_hit;
    assign status.needs_fit = (w_reg > m_reg) || (h_reg > m_reg);

    // shared restoring divider, one quotient bit per step
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg, den_reg;
    logic [DW:0]   div_try;
    logic          div_ge;
    logic [NW-1:0] div_num;
    logic [DW-1:0] div_den;
    logic [DW-1:0] quo_low;
    logic [DW-1:0] fit_q;

    assign div_try = {rem_reg, quo_reg[NW-1]};
    assign div_ge  = (div_try >= {1'b0, den_reg});
    assign quo_low = quo_reg[DW-1:0];
    assign fit_q   = (quo_low == '0) ? DW'(1) : quo_low;

    always_comb begin
        case (cmd.div_sel)
            DIV_FIT: begin
                // shorter side times max side over longest side
                div_num = (wide ? h_reg : w_reg) * m_reg;
                div_den = wide ? w_reg : h_reg;
            end
            DIV_COL: begin
                div_num = NW'(w_reg);
                div_den = fw_reg;
            end
            DIV_ROW: begin
                div_num = NW'(h_reg);
                div_den = fh_reg;
            end
            default: begin
                div_num = '0;
                div_den = DW'(1);
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (cmd.setup) begin
            w_reg <= clamp_dim(src_w_cfg_reg);
            h_reg <= clamp_dim(src_h_cfg_reg);
            m_reg <= clamp_dim(max_cfg_reg);
        end
        if (cmd.div_load) begin
            quo_reg <= div_num;
            rem_reg <= '0;
            den_reg <= div_den;
        end else if (cmd.div_step) begin
            quo_reg <= {quo_reg[NW-2:0], div_ge};
            rem_reg <= div_ge ? DW'(div_try - {1'b0, den_reg}) : div_try[DW-1:0];
        end
        if (cmd.fit_pass) begin
            fw_reg <= w_reg;
            fh_reg <= h_reg;
        end else if (cmd.fit_store) begin
            fw_reg <= wide ? m_reg : fit_q;
            fh_reg <= wide ? fit_q : m_reg;
        end
        if (cmd.col_store) begin
            col_q_reg <= quo_low;
            col_r_reg <= rem_reg;
        end
        if (cmd.row_store) begin
            row_q_reg <= quo_low;
            row_r_reg <= rem_reg;
        end
    end

    // raster position tracking
    logic [DW-1:0] scol_reg, scol_next, srow_reg, srow_next;
    logic [DW-1:0] tcol_reg, tcol_next, trow_reg, trow_next;
    logic [DW-1:0] nkcol_reg, nkcol_next, nkrow_reg, nkrow_next;
    logic [DW-1:0] crem_reg, crem_next, rrem_reg, rrem_next;
    logic [DW:0]   csum, rsum;
    logic          in_fire, row_kept, keep, col_end, row_end, last;
    logic          out_valid_reg;

    assign in_ready = cmd.run && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;
    assign row_kept = (srow_reg == nkrow_reg) && (trow_reg < fh_reg);
    assign keep     = row_kept && (scol_reg == nkcol_reg) && (tcol_reg < fw_reg);
    assign col_end  = ({1'b0, scol_reg} + 1'b1) >= {1'b0, w_reg};
    assign row_end  = ({1'b0, srow_reg} + 1'b1) >= {1'b0, h_reg};
    assign last     = (({1'b0, tcol_reg} + 1'b1) == {1'b0, fw_reg}) &&
                      (({1'b0, trow_reg} + 1'b1) == {1'b0, fh_reg});
    assign csum     = {1'b0, crem_reg} + {1'b0, col_r_reg};
    assign rsum     = {1'b0, rrem_reg} + {1'b0, row_r_reg};

    always_comb begin
        scol_next  = scol_reg;
        srow_next  = srow_reg;
        tcol_next  = tcol_reg;
        trow_next  = trow_reg;
        nkcol_next = nkcol_reg;
        nkrow_next = nkrow_reg;
        crem_next  = crem_reg;
        rrem_next  = rrem_reg;
        if (cmd.setup) begin
            scol_next  = '0;
            srow_next  = '0;
            tcol_next  = '0;
            trow_next  = '0;
            nkcol_next = '0;
            nkrow_next = '0;
            crem_next  = '0;
            rrem_next  = '0;
        end else if (in_fire) begin
            if (keep) begin
                tcol_next = tcol_reg + 1'b1;
                if (csum >= {1'b0, fw_reg}) begin
                    crem_next  = DW'(csum - {1'b0, fw_reg});
                    nkcol_next = nkcol_reg + col_q_reg + 1'b1;
                end else begin
                    crem_next  = csum[DW-1:0];
                    nkcol_next = nkcol_reg + col_q_reg;
                end
            end
            if (col_end) begin
                if (row_end) begin
                    scol_next  = '0;
                    srow_next  = '0;
                    tcol_next  = '0;
                    trow_next  = '0;
                    nkcol_next = '0;
                    nkrow_next = '0;
                    crem_next  = '0;
                    rrem_next  = '0;
                end else begin
                    if (row_kept) begin
                        trow_next = trow_reg + 1'b1;
                        if (rsum >= {1'b0, fh_reg}) begin
                            rrem_next  = DW'(rsum - {1'b0, fh_reg});
                            nkrow_next = nkrow_reg + row_q_reg + 1'b1;
                        end else begin
                            rrem_next  = rsum[DW-1:0];
                            nkrow_next = nkrow_reg + row_q_reg;
                        end
                    end
                    scol_next  = '0;
                    srow_next  = srow_reg + 1'b1;
                    tcol_next  = '0;
                    nkcol_next = '0;
                    crem_next  = '0;
                end
            end else begin
                scol_next = scol_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            scol_reg  <= '0;
            srow_reg  <= '0;
            tcol_reg  <= '0;
            trow_reg  <= '0;
            nkcol_reg <= '0;
            nkrow_reg <= '0;
            crem_reg  <= '0;
            rrem_reg  <= '0;
        end else begin
            scol_reg  <= scol_next;
            srow_reg  <= srow_next;
            tcol_reg  <= tcol_next;
            trow_reg  <= trow_next;
            nkcol_reg <= nkcol_next;
            nkrow_reg <= nkrow_next;
            crem_reg  <= crem_next;
            rrem_reg  <= rrem_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (in_fire && keep) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (in_fire && keep) begin
            out_pixel        <= swizzle_bgra(in_pixel);
            out_thumb_width  <= fw_reg[DIM_OUT_W-1:0];
            out_thumb_height <= fh_reg[DIM_OUT_W-1:0];
            out_frame_last   <= last;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> src/nearest_neighbor_thumbnail_scaler_core.sv
`default_nettype none

// nearest-neighbor thumbnail scaler. source rgba pixels come in raster order
// for a frame of source_width x source_height; when either side exceeds
// max_side the longest side is fitted to max_side and the other becomes
// floor(other*max_side/longest), at least 1, otherwise the thumbnail keeps
// the source size. only the source pixels that land on a thumbnail grid point
// leave the block, swizzled to bgra, with the thumbnail size and a flag on
// the final one. after reset and after every write to a defined register the
// block sets up the frame geometry with one shared restoring divider, one
// quotient bit per cycle over 2*DW bits (DW = 13 at the default dimension
// limit); no pixel is taken during the setup. after that, one pixel a cycle
// is taken, limited only by the single output register. writes to undefined
// register indexes are ignored.
module nearest_neighbor_thumbnail_scaler_core #(
    parameter int MAX_DIMENSION = 4096
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_wr_en,
    input  wire [nnts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire [nnts_pkg::CFG_W-1:0]     cfg_wr_data,
    nnts_pix_in_if.sink                   pix_in,
    nnts_pix_out_if.source                pix_out
);
    import nnts_pkg::*;

    // divider length follows from the internal dimension width
    localparam int CW = $clog2(MAX_DIMENSION + 1);
    localparam int DW = (CW > CFG_W) ? CW : CFG_W;
    localparam int NW = 2 * DW;

    nnts_cmd_t    cmd;
    nnts_status_t status;

    // sequencer: size setup then the run state
    nnts_ctrl #(
        .DIV_BITS (NW)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // registers, divider, raster tracking and output word register
    nnts_dp #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .cmd              (cmd),
        .status           (status),
        .in_valid         (pix_in.valid),
        .in_ready         (pix_in.ready),
        .in_pixel         (pix_in.pixel_rgba),
        .out_valid        (pix_out.valid),
        .out_ready        (pix_out.ready),
        .out_pixel        (pix_out.pixel_bgra),
        .out_thumb_width  (pix_out.thumb_width),
        .out_thumb_height (pix_out.thumb_height),
        .out_frame_last   (pix_out.frame_last)
    );

endmodule

`default_nettype wire

>>> src/nnts_checker.sv
`default_nettype none

module nnts_checker (
    input wire                           clk,
    input wire                           rst_n,
    input wire                           cfg_wr_en,
    input wire [nnts_pkg::CFG_IDX_W-1:0] cfg_index,
    input wire                           in_ready,
    input wire                           out_valid,
    input wire                           out_ready,
    input wire [nnts_pkg::PIX_W-1:0]     pixel_bgra,
    input wire [nnts_pkg::DIM_OUT_W-1:0] thumb_width,
    input wire [nnts_pkg::DIM_OUT_W-1:0] thumb_height,
    input wire                           frame_last
);
    import nnts_pkg::*;

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_bgra) &&
        $stable(thumb_width) && $stable(thumb_height) && $stable(frame_last))
        else $error("stalled output word changed");

    // a write to a defined register starts the size setup, so no pixel is taken next cycle
    a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en && (cfg_index == REG_SOURCE_WIDTH || cfg_index == REG_SOURCE_HEIGHT ||
        cfg_index == REG_MAX_SIDE) |=> !in_ready)
        else $error("pixel taken right after a register write");

    a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> thumb_width != '0 && thumb_height != '0)
        else $error("zero thumbnail size");

    // a one-pixel thumbnail only ever emits its final pixel
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && thumb_width == DIM_OUT_W'(1) && thumb_height == DIM_OUT_W'(1)
        |-> frame_last)
        else $error("one-pixel thumbnail without last flag");

endmodule

bind nearest_neighbor_thumbnail_scaler_core nnts_checker u_nnts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .in_ready     (pix_in.ready),
    .out_valid    (pix_out.valid),
    .out_ready    (pix_out.ready),
    .pixel_bgra   (pix_out.pixel_bgra),
    .thumb_width  (pix_out.thumb_width),
    .thumb_height (pix_out.thumb_height),
    .frame_last   (pix_out.frame_last)
);

`default_nettype wire

>>> tb/sv/nearest_neighbor_thumbnail_scaler_core_test.sv
`timescale 1ns / 100ps

module nearest_neighbor_thumbnail_scaler_core_test;
    import nnts_pkg::*;

    // settle time after the last expected word, covers the output register
    // and a pixel that produced no word
    localparam int SETTLE_CYCLES = 8;
    // each pixel costs at most a long sender gap plus a long sink stall, and a
    // setup follows each defined write, so this is far beyond a clean run
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_WORDS  = 650;
    localparam int DIM_LIMIT     = 4096;
    localparam int DIRECTED_ROWS = 30;

    // index past the register list, the block must ignore it entirely
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // one thumbnail word as it leaves the block
    typedef struct packed {
        logic [PIX_W-1:0]     bgra;
        logic [DIM_OUT_W-1:0] thumb_w;
        logic [DIM_OUT_W-1:0] thumb_h;
        logic                 last;
    } thumb_word_t;

    typedef enum logic {
        ROW_PIXEL,
        ROW_WRITE
    } row_kind_t;

    // directed stimulus row: a register write or a source pixel; pixel rows
    // with typed set carry the word to expect, the rest go to the predictor
    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_W-1:0]      data;
        logic [PIX_W-1:0]      pixel;
        logic                  typed;
        thumb_word_t           result;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wr_data;

    nnts_pix_in_if  pix_in ();
    nnts_pix_out_if pix_out ();

    nearest_neighbor_thumbnail_scaler_core #(
        .MAX_DIMENSION (DIM_LIMIT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .pix_in      (pix_in.sink),
        .pix_out     (pix_out.source)
    );

    always #1 clk = ~clk;

    // index and data are don't-care on pixel rows
    stim_row_t directed [DIRECTED_ROWS] = '{
        // after reset the frame is 1x1: every pixel is a whole thumbnail
        '{ROW_PIXEL, REG_SOURCE_WIDTH, 13'd0, 32'h00000000, 1'b1,
          '{32'h00000000, 13'd1, 13'd1, 1'b1}},
        '{ROW_PIXEL, REG_SOURCE_WIDTH, 13'd0, 32'hFFFFFFFF, 1'b1,
          '{32'hFFFFFFFF, 13'd1, 13'd1, 1'b1}},
        '{ROW_PIXEL, REG_SOURCE_WIDTH, 13'd0, 32'h12345678, 1'b1,
          '{32'h12785634, 13'd1, 13'd1, 1'b1}},
        '{ROW_PIXEL, REG_SOURCE_WIDTH, 13'd0, 32'hFF0000FF, 1'b1,
          '{32'hFFFF0000, 13'd1, 13'd1, 1'b1}},
        // zero width and height behave as one
        '{ROW_WRITE, REG_SOURCE_WIDTH, 13'd0, 32'h0, 1'b0, '0},
        '{ROW_WRITE, REG_SOURCE_HEIGHT, 13'd0, 32'h0, 1'b0, '0},
        '{ROW_PIXEL, REG_SOURCE_WIDTH, 13'd0, 32'hA5A55A5A, 1'b1,
          '{32'hA55A5AA5, 13'd1, 13'd1, 1'b1}},
        // zero max side acts as one, 3x2 source shrinks to a single pixel
        '{ROW_WRITE, REG_MAX_SIDE, 13'd0, 32'h0, 1'b0, '0},
        '{ROW_WRITE, REG_SOURCE_WIDTH, 13'd3, 32'h0, 1'b0, '0},
        '{ROW_WRITE, REG_SOURCE_HEIGHT, 13'd2, 32'h0, 1'b0, '0},
        '{ROW_PIXEL, REG_SOURCE_WIDTH, 13'd0, 32'h01020304, 1'b1,
          '{32'h01040302, 13'd1, 13'd1, 1'b1}},
        '{ROW_PIXEL, REG_SOURCE_WIDTH, 13'd0, 32'hDEADBEEF, 1'b0, '0},
        // write past the list mid-frame, must not restart the frame
        '{ROW_WRITE, REG_SPARE, 13'h1FFF, 32'h0, 1'b0, '0},
        '{ROW_PIXEL, REG_SOURCE_WIDTH, 13'd0, 32'h0BADF00D, 1'b0, '0},
        '{ROW_PIXEL, REG_SOURCE_WIDTH, 13'd0, 32'h5EED1234, 1'b0, '0},
        '{ROW_PIXEL, REG_SOURCE_WIDTH, 13'd0, 32'h87654321, 1'b0, '0},
        '{ROW_PIXEL, REG_SOURCE_WIDTH, 13'd0, 32'h0F0F0F0F, 1'b0, '0},
        // frame wrapped, next pixel opens a new frame
        '{ROW_PIXEL, REG_SOURCE_WIDTH, 13'd0, 32'hCAFEF00D, 1'b1,
          '{32'hCA0DF0FE, 13'd1, 13'd1, 1'b1}},
        // oversize width clamps to the limit, fitted to 512x1
        '{ROW_WRITE, REG_SOURCE_WIDTH, 13'h1FFF, 32'h0, 1'b0, '0},
        '{ROW_WRITE, REG_SOURCE_HEIGHT, 13'd1, 32'h0, 1'b0, '0},
        '{ROW_WRITE, REG_MAX_SIDE, 13'd512, 32'h0, 1'b0, '0},
        '{ROW_PIXEL, REG_SOURCE_WIDTH, 13'd0, 32'h11111111, 1'b0, '0},
        '{ROW_PIXEL, REG_SOURCE_WIDTH, 13'd0, 32'h22222222, 1'b0, '0},
        '{ROW_PIXEL, REG_SOURCE_WIDTH, 13'd0, 32'h33333333, 1'b0, '0},
        '{ROW_PIXEL, REG_SOURCE_WIDTH, 13'd0, 32'h44444444, 1'b0, '0},
        '{ROW_PIXEL, REG_SOURCE_WIDTH, 13'd0, 32'h55555555, 1'b0, '0},
        '{ROW_PIXEL, REG_SOURCE_WIDTH, 13'd0, 32'h66666666, 1'b0, '0},
        '{ROW_PIXEL, REG_SOURCE_WIDTH, 13'd0, 32'h77777777, 1'b0, '0},
        '{ROW_PIXEL, REG_SOURCE_WIDTH, 13'd0, 32'h88888888, 1'b0, '0},
        '{ROW_PIXEL, REG_SOURCE_WIDTH, 13'd0, 32'h99999999, 1'b0, '0}
    };

    // shadow of the register file
    logic [CFG_W-1:0] reg_width;
    logic [CFG_W-1:0] reg_height;
    logic [CFG_W-1:0] reg_max_side;

    // predicted frame geometry and raster position
    logic [12:0] fit_w;
    logic [12:0] fit_h;
    logic [13:0] src_col;
    logic [13:0] src_row;
    logic [13:0] tgt_col;
    logic [13:0] tgt_row;
    logic [13:0] keep_col;
    logic [13:0] keep_row;
    logic [13:0] col_rem;
    logic [13:0] row_rem;

    thumb_word_t pending_words [$];
    int          failures      = 0;
    int          cycle_count   = 0;
    bit          quiet         = 1'b0;
    int          out_stall_left = 0;

    // zero acts as one, anything past the limit acts as the limit
    function automatic logic [12:0] dim_in_range(input logic [CFG_W-1:0] v);
        if (v == '0)
            return 13'd1;
        if (v > DIM_LIMIT)
            return 13'(DIM_LIMIT);
        return 13'(v);
    endfunction

    function void rewind_position();
        src_col  = '0;
        src_row  = '0;
        tgt_col  = '0;
        tgt_row  = '0;
        keep_col = '0;
        keep_row = '0;
        col_rem  = '0;
        row_rem  = '0;
    endfunction

    // fit the longest side to max side, keep the aspect by exact floor
    function void fit_thumbnail();
        int unsigned w;
        int unsigned h;
        int unsigned m;
        int unsigned tw;
        int unsigned th;
        w  = dim_in_range(reg_width);
        h  = dim_in_range(reg_height);
        m  = dim_in_range(reg_max_side);
        tw = w;
        th = h;
        if (w > m || h > m) begin
            if (w >= h) begin
                tw = m;
                th = (h * m) / w;
            end else begin
                th = m;
                tw = (w * m) / h;
            end
        end
        if (tw < 1)
            tw = 1;
        if (th < 1)
            th = 1;
        fit_w = 13'(tw);
        fit_h = 13'(th);
        rewind_position();
    endfunction

    // one source pixel in raster order; kept when it sits on the next grid
    // point, grid steps by quotient and remainder of source over thumbnail
    function void sample_pixel(input logic [PIX_W-1:0] px, output bit kept,
                               output thumb_word_t word);
        int unsigned w;
        int unsigned h;
        bit          row_hit;
        w       = dim_in_range(reg_width);
        h       = dim_in_range(reg_height);
        kept    = 1'b0;
        word    = '0;
        row_hit = (src_row == keep_row) && (tgt_row < fit_h);

        if (row_hit && src_col == keep_col && tgt_col < fit_w) begin
            kept         = 1'b1;
            // red and blue change places
            word.bgra    = (px & 32'hFF00FF00) | ((px >> 16) & 32'h000000FF)
                         | ((px & 32'h000000FF) << 16);
            word.thumb_w = fit_w;
            word.thumb_h = fit_h;
            word.last    = (tgt_col + 1 == fit_w) && (tgt_row + 1 == fit_h);
            tgt_col      = tgt_col + 1;
            keep_col     = keep_col + 14'(w / fit_w);
            col_rem      = col_rem + 14'(w % fit_w);
            if (col_rem >= fit_w) begin
                col_rem  = col_rem - fit_w;
                keep_col = keep_col + 1;
            end
        end

        if (src_col + 1 >= w) begin
            // last pixel of the frame: everything back to the origin
            if (src_row + 1 >= h) begin
                rewind_position();
                return;
            end
            if (row_hit) begin
                tgt_row  = tgt_row + 1;
                keep_row = keep_row + 14'(h / fit_h);
                row_rem  = row_rem + 14'(h % fit_h);
                if (row_rem >= fit_h) begin
                    row_rem  = row_rem - fit_h;
                    keep_row = keep_row + 1;
                end
            end
            src_col  = '0;
            src_row  = src_row + 1;
            tgt_col  = '0;
            keep_col = '0;
            col_rem  = '0;
        end else begin
            src_col = src_col + 1;
        end
    endfunction

    // mostly short idles, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int sender_gap();
        if (quiet)
            return 0;
        if ($urandom_range(0, 1) == 0)
            return 0;
        return idle_len();
    endfunction

    function automatic logic [CFG_W-1:0] pick_max_side();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 13'(DIM_LIMIT);
            3:       return 13'd512;
            default: return 13'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_long_side();
        case ($urandom_range(0, 3))
            0:       return 13'(DIM_LIMIT);
            1:       return '1;
            2:       return 13'($urandom_range(DIM_LIMIT + 1, 8190));
            default: return 13'($urandom_range(100, DIM_LIMIT - 1));
        endcase
    endfunction

    // register write, only called with nothing in flight; the shadow and
    // the predicted frame follow at once
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        bit known;
        known       = 1'b1;
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_SOURCE_WIDTH:  reg_width    = value;
            REG_SOURCE_HEIGHT: reg_height   = value;
            REG_MAX_SIDE:      reg_max_side = value;
            default:           known        = 1'b0;
        endcase
        // undefined index: no restart, the frame carries on
        if (known)
            fit_thumbnail();
    endtask

    // one source word through the handshake; entered and left on a clock edge
    task automatic send_pixel(input logic [PIX_W-1:0] px, input int gap,
                              input bit typed, input thumb_word_t typed_word);
        bit          kept;
        thumb_word_t word;
        if (gap > 0) begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_in.valid      <= 1'b1;
        pix_in.pixel_rgba <= px;
        do
            @(posedge clk);
        while (pix_in.ready !== 1'b1);
        sample_pixel(px, kept, word);
        if (typed)
            pending_words = {pending_words, typed_word};
        else if (kept)
            pending_words = {pending_words, word};
    endtask

    // sender stops until every expected word is back
    task automatic hold_off();
        pix_in.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_words.size() != 0);
    endtask

    // fully idle: nothing expected and the pipe settled
    task automatic drain();
        hold_off();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // output side: check each accepted word, then pick the next ready
    always @(posedge clk) begin
        thumb_word_t want;
        if (rst_n === 1'b1 && pix_out.valid === 1'b1 && pix_out.ready === 1'b1) begin
            if (pending_words.size() == 0) begin
                $error("thumbnail word with none expected: pixel_bgra %h",
                       pix_out.pixel_bgra);
                failures++;
            end else begin
                want = pending_words.pop_front();
                if (pix_out.pixel_bgra !== want.bgra) begin
                    $error("pixel_bgra: expected %h, got %h", want.bgra,
                           pix_out.pixel_bgra);
                    failures++;
                end
                if (pix_out.thumb_width !== want.thumb_w) begin
                    $error("thumb_width: expected %0d, got %0d", want.thumb_w,
                           pix_out.thumb_width);
                    failures++;
                end
                if (pix_out.thumb_height !== want.thumb_h) begin
                    $error("thumb_height: expected %0d, got %0d", want.thumb_h,
                           pix_out.thumb_height);
                    failures++;
                end
                if (pix_out.frame_last !== want.last) begin
                    $error("frame_last: expected %0d, got %0d", want.last,
                           pix_out.frame_last);
                    failures++;
                end
            end
        end

        // random back-pressure, switched off in quiet phases
        if (quiet) begin
            pix_out.ready <= 1'b1;
        end else if (out_stall_left > 0) begin
            out_stall_left--;
            pix_out.ready <= 1'b0;
        end else if ($urandom_range(0, 99) < 25) begin
            out_stall_left = idle_len() - 1;
            pix_out.ready <= 1'b0;
        end else begin
            pix_out.ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int               row;
        int               random_words;
        int               shape;
        int               n_words;
        int               pause_at;
        int               first;
        int               frame_size;
        logic [CFG_W-1:0] setting [3];

        random_words      = 0;
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = REG_SOURCE_WIDTH;
        cfg_wr_data       = '0;
        pix_in.valid      = 1'b0;
        pix_in.pixel_rgba = '0;

        // predictor comes out of reset with the register defaults
        reg_width    = RST_SOURCE_WIDTH;
        reg_height   = RST_SOURCE_HEIGHT;
        reg_max_side = RST_MAX_SIDE;
        fit_thumbnail();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed table; writes wait until the pixels before them are done
        for (row = 0; row < DIRECTED_ROWS; row++) begin
            if (directed[row].kind == ROW_WRITE) begin
                if (row > 0 && directed[row - 1].kind == ROW_PIXEL)
                    drain();
                write_register(directed[row].index, directed[row].data);
            end else begin
                send_pixel(directed[row].pixel, sender_gap(), directed[row].typed,
                           directed[row].result);
            end
        end

        // random phases: new geometry, then a few frames or a partial one
        while (random_words < RANDOM_WORDS) begin
            drain();
            quiet = ($urandom_range(0, 4) == 0);
            shape = $urandom_range(0, 99);

            if (shape < 70) begin
                // small frames, whole frames go through many times
                setting[0] = 13'($urandom_range(0, 9));
                setting[1] = 13'($urandom_range(0, 9));
            end else if (shape < 82) begin
                // very wide, only part of the first rows is sent
                setting[0] = pick_long_side();
                setting[1] = 13'($urandom_range(1, 3));
            end else begin
                // very tall, a pixel or few per row
                setting[0] = 13'($urandom_range(1, 3));
                setting[1] = pick_long_side();
            end
            setting[2] = pick_max_side();

            if (shape >= 94) begin
                // only a stray write, the running frame must go on untouched
                write_register(REG_SPARE, 13'($urandom_range(0, 8191)));
            end else begin
                if ($urandom_range(0, 7) == 0)
                    write_register(REG_SPARE, 13'($urandom_range(0, 8191)));
                first = $urandom_range(0, 2);
                for (int k = 0; k < 3; k++) begin
                    // now and then one register keeps its old value
                    if (k == 2 && $urandom_range(0, 5) == 0)
                        continue;
                    write_register(CFG_IDX_W'((first + k) % 3), setting[(first + k) % 3]);
                end
            end

            frame_size = int'(dim_in_range(reg_width)) * int'(dim_in_range(reg_height));
            if (frame_size <= 40)
                n_words = $urandom_range(1, 3 * frame_size + 3);
            else
                n_words = $urandom_range(10, 60);
            pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_words - 1) : -1;

            for (int i = 0; i < n_words; i++) begin
                if (i == pause_at)
                    hold_off();
                send_pixel($urandom, sender_gap(), 1'b0, '0);
                random_words++;
            end
        end

        drain();
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
